/* hw/rtl/hcfd_pkg.sv */
package hcfd_pkg;

    typedef enum logic [2:0] {
        KIND_GIMBAL_DELTA  = 3'd0,
        KIND_SHOT_SPEED    = 3'd1,
        KIND_SHOT_MODE     = 3'd2,
        KIND_GIMBAL_TARGET = 3'd3,
        KIND_CHASSIS       = 3'd4
    } frame_kind_t;

    // configuration register indexes
    localparam logic [2:0] REG_CODE_GIMBAL_DELTA  = 3'd0;
    localparam logic [2:0] REG_CODE_SHOT_SPEED    = 3'd1;
    localparam logic [2:0] REG_CODE_SHOT_MODE     = 3'd2;
    localparam logic [2:0] REG_CODE_GIMBAL_TARGET = 3'd3;
    localparam logic [2:0] REG_CODE_CHASSIS       = 3'd4;
    localparam logic [2:0] REG_YAW_OFFSET         = 3'd5;
    localparam logic [2:0] REG_PITCH_OFFSET       = 3'd6;

    localparam int NUM_CODES = 5;
    localparam int NUM_BYTES = 6;
    localparam int NUM_PAIRS = 3;
    localparam int LEVEL_W   = 16;
    localparam int COEF_W    = 34;
    localparam int PROD_W    = LEVEL_W + COEF_W;
    localparam int COEF_SHIFT = 25;
    localparam int QW        = 24;
    localparam int VAL_W     = 26;
    localparam int ROT_W     = 18;
    localparam int OFF_W     = 25;
    localparam int SUM_W     = 27;

    localparam logic [7:0] HEADER_MIN = 8'd201;
    localparam logic [LEVEL_W-1:0] LEVEL_RADIX = 16'd200;

    // q = floor(p * M * 2048 / 625) = (p * ceil(M * 2^36 / 625)) >> 25, exact for p <= 40200
    localparam logic [COEF_W-1:0] COEF_M60 = COEF_W'(((64'd60 << 36) + 64'd624) / 64'd625);
    localparam logic [COEF_W-1:0] COEF_M30 = COEF_W'(((64'd30 << 36) + 64'd624) / 64'd625);
    localparam logic [COEF_W-1:0] COEF_M80 = COEF_W'(((64'd80 << 36) + 64'd624) / 64'd625);
    localparam logic [COEF_W-1:0] COEF_M50 = COEF_W'(((64'd50 << 36) + 64'd624) / 64'd625);
    localparam logic [COEF_W-1:0] COEF_M1  = COEF_W'(((64'd1 << 36) + 64'd624) / 64'd625);

    // channel half ranges in q16.16
    localparam logic signed [SUM_W-1:0] HALF_M60 = SUM_W'(60 * 65536);
    localparam logic signed [SUM_W-1:0] HALF_M30 = SUM_W'(30 * 65536);
    localparam logic signed [SUM_W-1:0] HALF_M80 = SUM_W'(80 * 65536);
    localparam logic signed [SUM_W-1:0] HALF_M50 = SUM_W'(50 * 65536);
    localparam logic signed [SUM_W-1:0] HALF_M1  = SUM_W'(65536);

    typedef struct packed {
        logic [NUM_CODES-1:0][7:0] codes;
        logic [OFF_W-1:0]          yaw_offset;
        logic [OFF_W-1:0]          pitch_offset;
    } cfg_t;

    typedef struct packed {
        frame_kind_t               kind;
        logic [NUM_BYTES-1:0][7:0] payload;
    } frame_t;

    typedef struct packed {
        frame_kind_t                kind;
        logic [7:0]                 raw;
        logic [NUM_PAIRS-1:0][QW-1:0] q;
    } scaled_t;

    typedef struct packed {
        frame_kind_t             kind;
        logic [VAL_W-1:0]        first_value;
        logic [VAL_W-1:0]        second_value;
        logic [ROT_W-1:0]        third_value;
    } result_t;

    function automatic logic [2:0] frame_len(frame_kind_t kind);
        logic [2:0] len;
        unique case (kind)
            KIND_GIMBAL_DELTA:  len = 3'd4;
            KIND_SHOT_SPEED:    len = 3'd1;
            KIND_SHOT_MODE:     len = 3'd1;
            KIND_GIMBAL_TARGET: len = 3'd4;
            KIND_CHASSIS:       len = 3'd6;
            default:            len = 3'd6;
        endcase
        return len;
    endfunction

endpackage

/* hw/rtl/host_command_frame_decoder.sv */
// Host command frame decoder: takes one received byte per cycle on s_axis and emits one
// decoded item on m_axis per completed frame. Bytes above 200 are headers; a header that
// matches a programmed code opens a frame, any other header just closes the open frame.
// Payload pairs are dequantized to Q16.16 with an exact constant multiply, so an item is
// accepted every cycle while the output side keeps up; the result of the byte that completes
// a frame passes the frame, product and output registers, and any of the three stages
// absorbs a stall. Code and offset registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while no frame is in flight; the block does not enforce it.
module host_command_frame_decoder
    import hcfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [24:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // first_value, second_value, third_value, 2 zero bits
    output logic [2:0]  m_axis_tuser    // frame_kind
);

    cfg_t    cfg_reg;
    logic    frame_valid, frame_ready;
    frame_t  frame_data;
    logic    scaled_valid, scaled_ready;
    scaled_t scaled_data;
    result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.codes[0]     <= 8'd201;
            cfg_reg.codes[1]     <= 8'd202;
            cfg_reg.codes[2]     <= 8'd203;
            cfg_reg.codes[3]     <= 8'd204;
            cfg_reg.codes[4]     <= 8'd205;
            cfg_reg.yaw_offset   <= '0;
            cfg_reg.pitch_offset <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CODE_GIMBAL_DELTA:  cfg_reg.codes[0] <= cfg_wdata[7:0];
                REG_CODE_SHOT_SPEED:    cfg_reg.codes[1] <= cfg_wdata[7:0];
                REG_CODE_SHOT_MODE:     cfg_reg.codes[2] <= cfg_wdata[7:0];
                REG_CODE_GIMBAL_TARGET: cfg_reg.codes[3] <= cfg_wdata[7:0];
                REG_CODE_CHASSIS:       cfg_reg.codes[4] <= cfg_wdata[7:0];
                REG_YAW_OFFSET:         cfg_reg.yaw_offset <= cfg_wdata;
                REG_PITCH_OFFSET:       cfg_reg.pitch_offset <= cfg_wdata;
                default:                ;
            endcase
        end
    end

    hcfd_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .out_valid (frame_valid),
        .out_ready (frame_ready),
        .out_data  (frame_data)
    );

    hcfd_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frame_valid),
        .in_ready  (frame_ready),
        .in_data   (frame_data),
        .out_valid (scaled_valid),
        .out_ready (scaled_ready),
        .out_data  (scaled_data)
    );

    hcfd_combine u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (scaled_valid),
        .in_ready  (scaled_ready),
        .in_data   (scaled_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

    assign m_axis_tdata = {2'b00, result.third_value, result.second_value, result.first_value};
    assign m_axis_tuser = result.kind;

endmodule

/* hw/rtl/hcfd_frame.sv */
module hcfd_frame
    import hcfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output frame_t     out_data
);

    logic        open_reg, open_next;
    frame_kind_t kind_reg, kind_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [7:0]  store_reg [NUM_BYTES];
    logic        valid_reg, valid_next;
    frame_t      frame_reg, frame_next;

    logic        accept;
    logic        is_header;
    logic        emit;
    logic [2:0]  cnt_inc;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign is_header = in_byte >= HEADER_MIN;
    assign cnt_inc   = cnt_reg + 3'd1;

    always_comb
    begin
        open_next = open_reg;
        kind_next = kind_reg;
        cnt_next  = cnt_reg;
        emit      = 1'b0;
        frame_next.kind = kind_reg;
        for (int i = 0; i < NUM_BYTES; i++)
        begin
            frame_next.payload[i] = (3'(i) == cnt_reg) ? in_byte : store_reg[i];
        end
        if (accept)
        begin
            if (is_header)
            begin
                cnt_next  = 3'd0;
                open_next = 1'b0;
                // descending so the lowest matching register wins
                for (int k = NUM_CODES - 1; k >= 0; k--)
                begin
                    if (cfg.codes[k] == in_byte)
                    begin
                        open_next = 1'b1;
                        kind_next = frame_kind_t'(3'(k));
                    end
                end
            end
            else if (open_reg)
            begin
                if (cnt_inc == frame_len(kind_reg))
                begin
                    emit      = 1'b1;
                    open_next = 1'b0;
                    cnt_next  = 3'd0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
        end
        valid_next = valid_reg;
        if (emit)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            kind_reg  <= KIND_GIMBAL_DELTA;
            cnt_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            open_reg  <= open_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !is_header && open_reg)
        begin
            store_reg[cnt_reg] <= in_byte;
        end
        if (emit)
        begin
            frame_reg <= frame_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = frame_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd5)
        else $error("payload count out of range");

    a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> cnt_reg == 3'd0)
        else $error("payload count nonzero with no frame open");

    a_header_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_header |=> cnt_reg == 3'd0)
        else $error("header did not restart the frame");

endmodule

/* hw/rtl/hcfd_scale.sv */
module hcfd_scale
    import hcfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  frame_t  in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output scaled_t out_data
);

    logic    valid_reg;
    scaled_t data_reg, data_next;
    logic    accept;

    logic [LEVEL_W-1:0] level [NUM_PAIRS];
    logic [COEF_W-1:0]  coef  [NUM_PAIRS];
    logic [PROD_W-1:0]  prod  [NUM_PAIRS];

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        unique case (in_data.kind)
            KIND_GIMBAL_DELTA:
            begin
                coef[0] = COEF_M60;
                coef[1] = COEF_M30;
            end
            KIND_GIMBAL_TARGET:
            begin
                coef[0] = COEF_M80;
                coef[1] = COEF_M50;
            end
            default:
            begin
                coef[0] = COEF_M1;
                coef[1] = COEF_M1;
            end
        endcase
        coef[2] = COEF_M1;

        data_next.kind = in_data.kind;
        data_next.raw  = in_data.payload[0];
        for (int i = 0; i < NUM_PAIRS; i++)
        begin
            level[i] = LEVEL_W'(in_data.payload[2*i]) * LEVEL_RADIX
                     + LEVEL_W'(in_data.payload[2*i+1]);
            prod[i]  = PROD_W'(level[i]) * PROD_W'(coef[i]);
            data_next.q[i] = prod[i][COEF_SHIFT +: QW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hw/rtl/hcfd_combine.sv */
module hcfd_combine
    import hcfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  scaled_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    valid_reg;
    result_t data_reg, data_next;
    logic    accept;

    logic signed [SUM_W-1:0] q0, q1, q2;
    logic signed [SUM_W-1:0] yaw_off, pitch_off;
    logic signed [SUM_W-1:0] first_sum, second_sum, third_sum;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        q0 = signed'(SUM_W'(in_data.q[0]));
        q1 = signed'(SUM_W'(in_data.q[1]));
        q2 = signed'(SUM_W'(in_data.q[2]));
        yaw_off   = SUM_W'(signed'(cfg.yaw_offset));
        pitch_off = SUM_W'(signed'(cfg.pitch_offset));
        third_sum = '0;
        unique case (in_data.kind)
            KIND_GIMBAL_DELTA:
            begin
                first_sum  = q0 - HALF_M60;
                second_sum = q1 - HALF_M30;
            end
            KIND_SHOT_SPEED, KIND_SHOT_MODE:
            begin
                first_sum  = signed'(SUM_W'(in_data.raw));
                second_sum = '0;
            end
            KIND_GIMBAL_TARGET:
            begin
                // yaw is negated before the offset
                first_sum  = HALF_M80 - q0 + yaw_off;
                second_sum = q1 - HALF_M50 + pitch_off;
            end
            default:
            begin
                first_sum  = q0 - HALF_M1;
                second_sum = q1 - HALF_M1;
                third_sum  = q2 - HALF_M1;
            end
        endcase
        data_next.kind         = in_data.kind;
        data_next.first_value  = first_sum[VAL_W-1:0];
        data_next.second_value = second_sum[VAL_W-1:0];
        data_next.third_value  = third_sum[ROT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    a_third_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.kind != KIND_CHASSIS |-> data_reg.third_value == '0)
        else $error("rotation speed set on a non-chassis item");

    a_shot_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (data_reg.kind == KIND_SHOT_SPEED || data_reg.kind == KIND_SHOT_MODE)
        |-> data_reg.second_value == '0 && data_reg.first_value[VAL_W-1:8] == '0)
        else $error("shot item carries more than its raw byte");

endmodule
